/* sv/mic_pkg.sv */
`timescale 1ns / 1ps

package mic_pkg;

  // Default number of hour slots held in the reach table
  localparam int MAX_LEN_DEF = 1024;

  // Field widths of the stream words
  localparam int RANGE_W = 11;
  localparam int OUT_W   = 11;
  localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

  // Result status codes
  typedef enum logic [1:0] {
    ST_COVERED     = 2'd0,
    ST_UNCOVERABLE = 2'd1,
    ST_OVERFLOW    = 2'd2
  } mic_status_t;

  // Controller states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_UPDATE,
    S_SCAN,
    S_DONE
  } mic_state_t;

  // Result handed from the controller to the output register
  typedef struct packed {
    logic              valid;
    logic [OUT_W-1:0]  workers;
    mic_status_t       status;
  } mic_result_t;

endpackage

/* sv/mic_table.sv */
`timescale 1ns / 1ps

module mic_table #(
  parameter int DEPTH = mic_pkg::MAX_LEN_DEF,
  parameter int AW    = $clog2(DEPTH),
  parameter int DW    = AW + 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* sv/mic_ctrl.sv */
`timescale 1ns / 1ps

module mic_ctrl #(
  parameter int MAX_LEN = mic_pkg::MAX_LEN_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // slot words
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic signed [mic_pkg::RANGE_W-1:0] in_range,
  input  logic                              in_last,
  // result handoff
  input  logic                              res_ready,
  output mic_pkg::mic_result_t              res,
  // reach table port
  output logic                              mem_we,
  output logic [$clog2(MAX_LEN)-1:0]        mem_waddr,
  output logic [$clog2(MAX_LEN):0]          mem_wdata,
  output logic [$clog2(MAX_LEN)-1:0]        mem_raddr,
  input  logic [$clog2(MAX_LEN):0]          mem_rdata
);

  localparam int AW = $clog2(MAX_LEN);
  localparam int CW = ((AW > mic_pkg::RANGE_W) ? AW : mic_pkg::RANGE_W) + 2;
  localparam int WW = ((AW + 1) > mic_pkg::OUT_W) ? (AW + 1) : mic_pkg::OUT_W;
  localparam logic signed [CW-1:0] RIGHT_MAX = CW'(MAX_LEN - 1);
  localparam logic [AW:0] FULL_COUNT = (AW + 1)'(MAX_LEN);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_LEN - 1);
  localparam logic [AW:0] EMPTY = {(AW + 1){1'b1}};

  mic_pkg::mic_state_t state_r, state_nxt;

  logic [AW-1:0]      clr_addr_r, clr_addr_nxt;
  logic [AW:0]        slot_count_r, slot_count_nxt;
  logic               overflow_r, overflow_nxt;
  logic signed [AW:0] cov_r, cov_nxt;
  logic signed [AW:0] best_r, best_nxt;
  logic [AW:0]        cnt_r, cnt_nxt;
  logic               unc_r, unc_nxt;
  logic [AW:0]        rd_idx_r, rd_idx_nxt;
  logic               p_v_r, p_v_nxt;
  logic [AW-1:0]      p_idx_r, p_idx_nxt;
  logic [AW-1:0]      left_r, left_nxt;
  logic [AW-1:0]      right_r, right_nxt;
  logic               have_r, have_nxt;
  logic               last_r, last_nxt;

  logic               accept;
  logic               full;
  logic signed [CW-1:0] pos_s, reach_s, left_full, right_full;
  logic [AW-1:0]      left_c, right_c;
  logic               scan_issue;
  logic signed [AW:0] rd_s, here_s, best_s;
  logic               do_write;
  logic [WW-1:0]      cnt_w;

  // load address math: interval [pos - reach, pos + reach], clipped
  assign full      = (slot_count_r == FULL_COUNT);
  assign pos_s     = $signed({{(CW - AW - 1){1'b0}}, slot_count_r});
  assign reach_s   = CW'(in_range);
  assign left_full = pos_s - reach_s;
  assign right_full = pos_s + reach_s;
  assign left_c    = left_full[CW-1] ? '0 : left_full[AW-1:0];
  assign right_c   = (right_full > RIGHT_MAX) ? LAST_ADDR : right_full[AW-1:0];

  assign accept     = in_tvalid && in_tready;
  assign scan_issue = (state_r == mic_pkg::S_SCAN) && (rd_idx_r != slot_count_r);

  assign rd_s     = $signed(mem_rdata);
  assign here_s   = $signed({1'b0, p_idx_r});
  assign best_s   = (rd_s > best_r) ? rd_s : best_r;
  assign do_write = have_r && (rd_s < $signed({1'b0, right_r}));
  assign cnt_w    = WW'(cnt_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mic_pkg::S_CLEAR:  if (clr_addr_r == LAST_ADDR) state_nxt = mic_pkg::S_IDLE;
      mic_pkg::S_IDLE:   if (accept) state_nxt = mic_pkg::S_UPDATE;
      mic_pkg::S_UPDATE: state_nxt = last_r ? mic_pkg::S_SCAN : mic_pkg::S_IDLE;
      mic_pkg::S_SCAN: begin
        if ((rd_idx_r == slot_count_r) && !p_v_r) state_nxt = mic_pkg::S_DONE;
      end
      mic_pkg::S_DONE:   if (res_ready) state_nxt = mic_pkg::S_IDLE;
      default:           state_nxt = mic_pkg::S_CLEAR;
    endcase
  end

  // outputs: handshake, table port, result
  always_comb begin
    in_tready   = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = left_r;
    mem_wdata   = EMPTY;
    mem_raddr   = left_c;
    res.valid   = 1'b0;
    res.workers = '0;
    res.status  = mic_pkg::ST_COVERED;
    if (overflow_r) begin
      res.status = mic_pkg::ST_OVERFLOW;
    end else if (unc_r) begin
      res.status = mic_pkg::ST_UNCOVERABLE;
    end else begin
      res.workers = (cnt_w > WW'(mic_pkg::OUT_MAX)) ? mic_pkg::OUT_MAX
                                                   : mic_pkg::OUT_W'(cnt_r);
    end
    case (state_r)
      mic_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_r;
      end
      mic_pkg::S_IDLE: in_tready = 1'b1;
      mic_pkg::S_UPDATE: begin
        mem_we    = do_write;
        mem_wdata = {1'b0, right_r};
      end
      mic_pkg::S_SCAN: begin
        mem_raddr = rd_idx_r[AW-1:0];
        mem_we    = p_v_r;
        mem_waddr = p_idx_r;
      end
      mic_pkg::S_DONE: res.valid = res_ready;
      default: ;
    endcase
  end

  // datapath next values
  always_comb begin
    clr_addr_nxt   = clr_addr_r;
    slot_count_nxt = slot_count_r;
    overflow_nxt   = overflow_r;
    cov_nxt        = cov_r;
    best_nxt       = best_r;
    cnt_nxt        = cnt_r;
    unc_nxt        = unc_r;
    rd_idx_nxt     = rd_idx_r;
    p_v_nxt        = 1'b0;
    p_idx_nxt      = rd_idx_r[AW-1:0];
    left_nxt       = left_r;
    right_nxt      = right_r;
    have_nxt       = have_r;
    last_nxt       = last_r;

    if (state_r == mic_pkg::S_CLEAR) begin
      clr_addr_nxt = clr_addr_r + 1'b1;
    end

    // latch one slot word; the table read of its left end goes out now
    if (accept) begin
      left_nxt  = left_c;
      right_nxt = right_c;
      have_nxt  = !in_range[mic_pkg::RANGE_W-1] && !full;
      last_nxt  = in_last;
      if (full) begin
        overflow_nxt = 1'b1;
      end else begin
        slot_count_nxt = slot_count_r + 1'b1;
      end
    end

    // scan: issue reads ahead, process the word read the cycle before
    if (scan_issue) begin
      rd_idx_nxt = rd_idx_r + 1'b1;
      p_v_nxt    = 1'b1;
    end
    if (p_v_r) begin
      best_nxt = best_s;
      if (!unc_r && (cov_r < here_s)) begin
        if (best_s < here_s) begin
          unc_nxt = 1'b1;
        end else begin
          cov_nxt = best_s;
          cnt_nxt = cnt_r + 1'b1;
        end
      end
    end

    // set done: back to empty-set values
    if (res.valid) begin
      slot_count_nxt = '0;
      overflow_nxt   = 1'b0;
      cov_nxt        = EMPTY;
      best_nxt       = EMPTY;
      cnt_nxt        = '0;
      unc_nxt        = 1'b0;
      rd_idx_nxt     = '0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= mic_pkg::S_CLEAR;
      clr_addr_r   <= '0;
      slot_count_r <= '0;
      overflow_r   <= 1'b0;
      cov_r        <= EMPTY;
      best_r       <= EMPTY;
      cnt_r        <= '0;
      unc_r        <= 1'b0;
      rd_idx_r     <= '0;
      p_v_r        <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_addr_r   <= clr_addr_nxt;
      slot_count_r <= slot_count_nxt;
      overflow_r   <= overflow_nxt;
      cov_r        <= cov_nxt;
      best_r       <= best_nxt;
      cnt_r        <= cnt_nxt;
      unc_r        <= unc_nxt;
      rd_idx_r     <= rd_idx_nxt;
      p_v_r        <= p_v_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    p_idx_r <= p_idx_nxt;
    left_r  <= left_nxt;
    right_r <= right_nxt;
    have_r  <= have_nxt;
    last_r  <= last_nxt;
  end

endmodule

/* sv/min_interval_cover_table_scan_top.sv */
`timescale 1ns / 1ps

// Channel  Ports                          Word
// in       in_tvalid/tready/tdata/tlast   one hour slot: reach, tlast = last slot
// out      out_tvalid/tready/tdata/tuser  one result per set: count and status
//
// Each slot word is a table read of its left end, then a write back. The last
// word of a set adds a scan (one table read per slot, pipelined one deep) and
// a handoff of the result. After reset a clearing pass fills the table; no
// word is taken during it. New slot words are taken while a result waits on
// out_tready; a finished scan holds until the output register is free.

module min_interval_cover_table_scan_top #(
  parameter int MAX_LEN = mic_pkg::MAX_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [10:0] worker_range (signed)
  input  logic        in_tlast,   // last_hour
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [10:0] workers_needed
  output logic [1:0]  out_tuser   // [1:0] status
);

  localparam int AW = $clog2(MAX_LEN);

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [AW:0]           mem_wdata;
  logic [AW-1:0]         mem_raddr;
  logic [AW:0]           mem_rdata;
  mic_pkg::mic_result_t  res;
  logic                  res_ready;

  logic                        out_valid_r, out_valid_nxt;
  logic [mic_pkg::OUT_W-1:0]   out_workers_r;
  mic_pkg::mic_status_t        out_status_r;

  mic_table #(
    .DEPTH (MAX_LEN)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  mic_ctrl #(
    .MAX_LEN (MAX_LEN)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_range  ($signed(in_tdata[mic_pkg::RANGE_W-1:0])),
    .in_last   (in_tlast),
    .res_ready (res_ready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // output register: free when empty or being taken
  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res.valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_workers_r <= res.workers;
      out_status_r  <= res.status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(16 - mic_pkg::OUT_W){1'b0}}, out_workers_r};
  assign out_tuser  = out_status_r;

`ifndef ASSERT_OFF
  // a result only moves into a free output register
  a_res_free: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> res_ready)
    else $error("result handed off while output register busy");

  // slot words are never taken while a result is being produced
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> !in_tready)
    else $error("input ready during result handoff");

  // a failed set carries a zero count
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser != mic_pkg::ST_COVERED)) |-> (out_tdata == 16'd0))
    else $error("nonzero count with failure status");

  // table writes come only from clearing, updates or the scan
  a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> !in_tready)
    else $error("table write while idle");
`endif

endmodule
